### design/message_dedup_slot_allocator_assert.svh
// Assertion macros shared by the checker files of the slot allocator.
`ifndef MESSAGE_DEDUP_SLOT_ALLOCATOR_ASSERT_SVH
`define MESSAGE_DEDUP_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MDSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MDSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/mdsa_pkg.sv
// Shared constants and types of the message slot allocator.
package mdsa_pkg;

	localparam int SLOT_COUNT_DEF   = 16;
	localparam int HEADER_BYTES_DEF = 16;

	localparam int BYTE_W     = 8;
	localparam int REF_W      = 16;
	localparam int LEN_W      = 9;
	localparam int TIME_W     = 32;
	localparam int SLOT_OUT_W = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ANNOUNCEMENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNATURE    = 1'b1;

	localparam logic [CFG_DATA_W-1:0] ANNOUNCEMENT_RST = 8'd0;
	localparam logic [CFG_DATA_W-1:0] SIGNATURE_RST    = 8'd1;

	localparam logic FUNC_REMEMBER = 1'b0;
	localparam logic FUNC_FORGET   = 1'b1;

	// One slot as seen by the compare unit; an invalid slot reads as zero.
	typedef struct packed {
		logic             valid;
		logic [REF_W-1:0] reference;
		logic [LEN_W-1:0] length;
	} slot_entry_t;

	// Outcome of comparing one slot against the key.
	typedef struct packed {
		logic hit;
		logic free;
	} slot_cmp_t;

endpackage

### design/mdsa_ifs.sv
// Valid/ready channel interfaces for the slot allocator's input and result beats.
interface mdsa_in_if import mdsa_pkg::*;;
	logic              valid;
	logic              ready;
	logic              func;
	logic [BYTE_W-1:0] msg_type;
	logic [BYTE_W-1:0] byte_zero;
	logic [BYTE_W-1:0] byte_one;
	logic [BYTE_W-1:0] byte_two;
	logic [BYTE_W-1:0] body_length;
	logic [BYTE_W-1:0] frame_length;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, func, msg_type, byte_zero, byte_one, byte_two,
		body_length, frame_length, now_ms, input ready);
	modport sink (input valid, func, msg_type, byte_zero, byte_one, byte_two,
		body_length, frame_length, now_ms, output ready);
endinterface

interface mdsa_out_if import mdsa_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic                  stored;
	logic                  duplicate;
	logic [SLOT_OUT_W-1:0] slot;
	logic                  evicted;

	modport source (output valid, stored, duplicate, slot, evicted, input ready);
	modport sink (input valid, stored, duplicate, slot, evicted, output ready);
endinterface

### design/mdsa_match.sv
// Shared compare unit: tests one slot against the key and reports whether it is free.
module mdsa_match import mdsa_pkg::*; (
	input  slot_entry_t      entry,
	input  logic [REF_W-1:0] key_ref,
	input  logic [LEN_W-1:0] key_len,
	output slot_cmp_t        result
);

	always_comb begin
		result.hit  = (entry.reference == key_ref) && (entry.length == key_len);
		result.free = !entry.valid;
	end

endmodule

### design/mdsa_slot_mem.sv
// Slot table: valid flags in flip-flops, reference, length and time in a memory.
module mdsa_slot_mem import mdsa_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          rd_en,
	input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
	output slot_entry_t                   rd_entry,
	input  logic                          wr_en,
	input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
	input  logic [REF_W-1:0]              wr_ref,
	input  logic [LEN_W-1:0]              wr_len,
	input  logic [TIME_W-1:0]             wr_time
);

	logic [SLOT_COUNT-1:0] valid_q;
	logic [REF_W-1:0]      ref_mem  [SLOT_COUNT];
	logic [LEN_W-1:0]      len_mem  [SLOT_COUNT];
	logic [TIME_W-1:0]     time_mem [SLOT_COUNT];
	logic                  rd_valid_q;
	logic [REF_W-1:0]      rd_ref_q;
	logic [LEN_W-1:0]      rd_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ref_mem[wr_addr]  <= wr_ref;
			len_mem[wr_addr]  <= wr_len;
			time_mem[wr_addr] <= wr_time;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_valid_q <= valid_q[rd_addr];
			rd_ref_q   <= ref_mem[rd_addr];
			rd_len_q   <= len_mem[rd_addr];
		end
	end

	// A slot that was never written since the last clear reads as all zero.
	always_comb begin
		rd_entry.valid     = rd_valid_q;
		rd_entry.reference = rd_valid_q ? rd_ref_q : '0;
		rd_entry.length    = rd_valid_q ? rd_len_q : '0;
	end

endmodule

### design/message_dedup_slot_allocator.sv
// Top level of the message slot allocator with duplicate filtering.
//
// The block keeps SLOT_COUNT message slots and, for every remember beat,
// decides whether the message is a duplicate and otherwise which slot it
// goes to: slot 0 when the table is empty, else the lowest free slot, else
// the oldest slot, which is then marked evicted. A forget beat clears the
// whole table and answers with an all-zero result. A remember beat scans
// the table, reading one slot per cycle through the single read port of
// the slot memory and feeding it to one shared compare unit, then writes
// its slot unless it is a duplicate, and its result is loaded into the
// output register once that register is empty or being read. A forget beat
// goes straight to its result. The input is ready again on the cycle after
// the result is loaded, so no new beat is taken before the last result is
// loaded. The input is ready only while the sequencer is idle, but a
// finished result may wait in the output register while the next beat is
// already being taken.
// There is no clearing pass: each slot has a valid flag that reset or forget
// clears at once, and an invalid slot reads as reference 0 and length 0.
// Configuration writes are accepted on any cycle but are meant to happen
// only while the block is idle.
module message_dedup_slot_allocator import mdsa_pkg::*; #(
	parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mdsa_in_if.sink               req,
	mdsa_out_if.source            rsp
);

	localparam int                SLOT_W    = $clog2(SLOT_COUNT);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
	localparam logic [LEN_W-1:0]  HDR_LEN   = LEN_W'(HEADER_BYTES);

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_WRITE  = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] ann_type_q;
	logic [CFG_DATA_W-1:0] sig_type_q;

	// Key and write data captured with the beat.
	logic [REF_W-1:0]  key_ref_q;
	logic [LEN_W-1:0]  key_len_q;
	logic [LEN_W-1:0]  frame_len_q;
	logic [TIME_W-1:0] now_q;

	// Scan control: the read is issued in one cycle and compared in the next.
	logic [SLOT_W-1:0] scan_cnt_q;
	logic              issuing_q;
	logic              cmp_vld_s1;
	logic              cmp_last_s1;
	logic [SLOT_W-1:0] cmp_idx_s1;

	// Scan outcome.
	logic              dup_q;
	logic              found_q;
	logic [SLOT_W-1:0] free_idx_q;

	// Replacement state.
	logic [SLOT_W-1:0] oldest_q;
	logic              empty_q;

	// Finished result waiting for the output register.
	logic                  res_stored_q;
	logic                  res_dup_q;
	logic [SLOT_OUT_W-1:0] res_slot_q;
	logic                  res_evict_q;

	// Output register.
	logic                  out_valid_q;
	logic                  out_stored_q;
	logic                  out_dup_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;
	logic                  out_evict_q;

	logic              in_fire;
	logic              forget;
	logic              rd_en;
	logic              wr_en;
	logic              out_load;
	logic [REF_W-1:0]  beat_ref;
	logic [SLOT_W-1:0] target;
	logic              evict;
	slot_entry_t       rd_entry;
	slot_cmp_t         cmp;

	assign req.ready = (state_q == ST_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign forget    = in_fire && (req.func == FUNC_FORGET);
	assign rd_en     = (state_q == ST_SCAN) && issuing_q;
	assign wr_en     = (state_q == ST_WRITE) && !dup_q;
	assign out_load  = (state_q == ST_RESULT) && (!out_valid_q || rsp.ready);

	// The announcement rule wins when both registers hold the same type code.
	always_comb begin
		if (req.msg_type == ann_type_q) begin
			beat_ref = {req.byte_two, req.byte_one};
		end else if (req.msg_type == sig_type_q) begin
			beat_ref = {req.byte_one, req.byte_zero};
		end else begin
			beat_ref = '0;
		end
	end

	// Placement: slot 0 on an empty table, the first free slot, or the oldest.
	always_comb begin
		target = free_idx_q;
		evict  = 1'b0;
		if (empty_q) begin
			target = '0;
		end else if (!found_q) begin
			target = oldest_q;
			evict  = 1'b1;
		end
	end

	mdsa_slot_mem #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (forget),
		.rd_en    (rd_en),
		.rd_addr  (scan_cnt_q),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (target),
		.wr_ref   (key_ref_q),
		.wr_len   (frame_len_q),
		.wr_time  (now_q)
	);

	mdsa_match u_match (
		.entry   (rd_entry),
		.key_ref (key_ref_q),
		.key_len (key_len_q),
		.result  (cmp)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ann_type_q <= ANNOUNCEMENT_RST;
			sig_type_q <= SIGNATURE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ANNOUNCEMENT: ann_type_q <= cfg_data;
				REG_SIGNATURE:    sig_type_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Sequencer, scan bookkeeping and table control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_cnt_q   <= '0;
			issuing_q    <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			cmp_last_s1  <= 1'b0;
			dup_q        <= 1'b0;
			found_q      <= 1'b0;
			oldest_q     <= '0;
			empty_q      <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			cmp_vld_s1  <= rd_en;
			cmp_last_s1 <= rd_en && (scan_cnt_q == LAST_SLOT);

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (forget) begin
						oldest_q <= '0;
						empty_q  <= 1'b1;
						state_q  <= ST_RESULT;
					end else if (in_fire) begin
						scan_cnt_q <= '0;
						issuing_q  <= 1'b1;
						dup_q      <= 1'b0;
						found_q    <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
						if (scan_cnt_q == LAST_SLOT) begin
							issuing_q <= 1'b0;
						end
					end
					if (cmp_vld_s1) begin
						if (cmp.hit) begin
							dup_q <= 1'b1;
						end
						if (cmp.free && !found_q) begin
							found_q <= 1'b1;
						end
						if (cmp_last_s1) begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					if (!dup_q) begin
						empty_q <= 1'b0;
						if (empty_q) begin
							oldest_q <= '0;
						end else if (evict) begin
							oldest_q <= (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
						end
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers; they follow the control state above.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_ref_q   <= beat_ref;
			key_len_q   <= HDR_LEN + LEN_W'(req.body_length);
			frame_len_q <= LEN_W'(req.frame_length);
			now_q       <= req.now_ms;
		end
		if (forget) begin
			res_stored_q <= 1'b0;
			res_dup_q    <= 1'b0;
			res_slot_q   <= '0;
			res_evict_q  <= 1'b0;
		end
		if ((state_q == ST_SCAN) && cmp_vld_s1 && cmp.free && !found_q) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (rd_en) begin
			cmp_idx_s1 <= scan_cnt_q;
		end
		if (state_q == ST_WRITE) begin
			res_stored_q <= !dup_q;
			res_dup_q    <= dup_q;
			res_slot_q   <= dup_q ? '0 : SLOT_OUT_W'(target);
			res_evict_q  <= !dup_q && evict;
		end
		if (out_load) begin
			out_stored_q <= res_stored_q;
			out_dup_q    <= res_dup_q;
			out_slot_q   <= res_slot_q;
			out_evict_q  <= res_evict_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.stored    = out_stored_q;
	assign rsp.duplicate = out_dup_q;
	assign rsp.slot      = out_slot_q;
	assign rsp.evicted   = out_evict_q;

endmodule

### design/mdsa_checker.sv
// Port-level checker of the slot allocator and its bind to the top level.
`include "message_dedup_slot_allocator_assert.svh"

module mdsa_checker import mdsa_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  out_stored,
	input logic                  out_duplicate,
	input logic [SLOT_OUT_W-1:0] out_slot,
	input logic                  out_evicted
);

	// A result is either a stored slot or a duplicate, never both.
	`MDSA_ASSERT_IMP(a_stored_xor_dup, clk, arst_n, out_valid, !(out_stored && out_duplicate), "result is both stored and duplicate")

	// An eviction only happens when the message was written.
	`MDSA_ASSERT_IMP(a_evict_needs_store, clk, arst_n, out_valid && out_evicted, out_stored, "eviction without a store")

	// Nothing stored means slot zero.
	`MDSA_ASSERT_IMP(a_slot_zero, clk, arst_n, out_valid && !out_stored, out_slot == '0, "slot nonzero without a store")

	// The sequencer works on one beat at a time.
	`MDSA_ASSERT_NXT(a_one_beat, clk, arst_n, in_valid && in_ready, !in_ready, "input ready right after a beat")

	// A stalled result beat holds.
	`MDSA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_slot) && $stable(out_stored) && $stable(out_duplicate) && $stable(out_evicted), "stalled result changed")

endmodule

bind message_dedup_slot_allocator mdsa_checker u_mdsa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (req.valid),
	.in_ready      (req.ready),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.out_stored    (rsp.stored),
	.out_duplicate (rsp.duplicate),
	.out_slot      (rsp.slot),
	.out_evicted   (rsp.evicted)
);

### sim/tb.sv
// Self-checking testbench for the duplicate-filtering message slot allocator.
module tb;
	import mdsa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The longest quiet stretch in a correct run is the deliberate receiver
	// hold plus one beat of latency and a long sender gap, so the watchdog
	// limit is several times that.
	localparam int HOLD_CYCLES    = 250;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 40;
	localparam int PHASES         = 5;
	localparam int PHASE_ITEMS    = 188;
	localparam int HISTORY_DEPTH  = 48;

	typedef struct packed {
		logic              func;
		logic [BYTE_W-1:0] msg_type;
		logic [BYTE_W-1:0] byte_zero;
		logic [BYTE_W-1:0] byte_one;
		logic [BYTE_W-1:0] byte_two;
		logic [BYTE_W-1:0] body_length;
		logic [BYTE_W-1:0] frame_length;
		logic [TIME_W-1:0] now_ms;
	} msg_t;

	typedef struct packed {
		logic                  stored;
		logic                  duplicate;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  evicted;
	} outcome_t;

	// Tracks the slot table as the block should hold it and keeps the outcomes
	// that are still on their way out of the block, oldest first.
	class slot_allocation_tracker;
		logic [BYTE_W-1:0] announce_code;
		logic [BYTE_W-1:0] signature_code;
		bit                used   [SLOT_COUNT_DEF];
		logic [REF_W-1:0]  refs   [SLOT_COUNT_DEF];
		logic [LEN_W-1:0]  lens   [SLOT_COUNT_DEF];
		logic [TIME_W-1:0] stamps [SLOT_COUNT_DEF];
		int                oldest;
		bit                is_empty;
		outcome_t          awaited[$];
		int                mismatches;

		function new();
			announce_code = ANNOUNCEMENT_RST;
			signature_code = SIGNATURE_RST;
			mismatches = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (used[i]) begin
				used[i] = 1'b0;
				refs[i] = '0;
				lens[i] = '0;
				stamps[i] = '0;
			end
			oldest = 0;
			is_empty = 1'b1;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_ANNOUNCEMENT: announce_code = value;
				REG_SIGNATURE:    signature_code = value;
				default:          ;
			endcase
		endfunction

		// Works out the outcome of one accepted input beat and updates the table.
		function void note_message(msg_t m);
			outcome_t         o;
			logic [REF_W-1:0] key;
			logic [LEN_W-1:0] size;
			int               target;
			bit               hit;
			bit               found;
			o = '0;
			key = '0;
			target = 0;
			hit = 1'b0;
			found = 1'b0;
			if (m.func == FUNC_FORGET) begin
				wipe();
			end else begin
				// The announcement rule wins when both codes are equal.
				if (m.msg_type == announce_code)
					key = {m.byte_two, m.byte_one};
				else if (m.msg_type == signature_code)
					key = {m.byte_one, m.byte_zero};
				size = LEN_W'(HEADER_BYTES_DEF) + LEN_W'(m.body_length);
				// Every slot takes part in the match, whether valid or not.
				foreach (refs[i])
					if (refs[i] == key && lens[i] == size)
						hit = 1'b1;
				if (hit) begin
					o.duplicate = 1'b1;
				end else begin
					if (is_empty) begin
						target = 0;
						oldest = 0;
						is_empty = 1'b0;
					end else begin
						foreach (used[i])
							if (!found && !used[i]) begin
								target = i;
								found = 1'b1;
							end
						if (!found) begin
							target = oldest;
							oldest = (target + 1) % SLOT_COUNT_DEF;
							o.evicted = 1'b1;
						end
					end
					used[target] = 1'b1;
					refs[target] = key;
					lens[target] = LEN_W'(m.frame_length);
					stamps[target] = m.now_ms;
					o.stored = 1'b1;
					o.slot = SLOT_OUT_W'(target);
				end
			end
			awaited.push_back(o);
		endfunction

		function void check_outcome(outcome_t got);
			outcome_t want;
			if (awaited.size() == 0) begin
				$error("result beat arrived with no message awaiting a result");
				mismatches++;
			end else begin
				want = awaited.pop_front();
				if (got.stored !== want.stored) begin
					$error("stored: expected %0d, got %0d", want.stored, got.stored);
					mismatches++;
				end
				if (got.duplicate !== want.duplicate) begin
					$error("duplicate: expected %0d, got %0d", want.duplicate, got.duplicate);
					mismatches++;
				end
				if (got.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, got.slot);
					mismatches++;
				end
				if (got.evicted !== want.evicted) begin
					$error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mdsa_in_if  req_ch();
	mdsa_out_if rsp_ch();

	slot_allocation_tracker tracker = new();

	// Recently sent remember beats; replaying them is what produces duplicates.
	msg_t recent_messages[$];

	// While steady is set neither side inserts random idle cycles.
	bit steady = 1'b0;
	// Set by the stimulus to make the receiver hold off for a long stretch.
	bit hold_request = 1'b0;

	logic [CFG_DATA_W-1:0] announce_plan  [PHASES] = '{8'd255, 8'd9, 8'd0, 8'd0, 8'd1};
	logic [CFG_DATA_W-1:0] signature_plan [PHASES] = '{8'd0, 8'd9, 8'd255, 8'd0, 8'd0};

	message_dedup_slot_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle stretches mostly come from the shortest of three ranges, sometimes
	// from the middle one, and now and then let the block run completely dry.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pause_before();
		if (steady || $urandom_range(0, 99) >= 40)
			return 0;
		return idle_length();
	endfunction

	function automatic msg_t compose(logic f, int kind, int b0, int b1, int b2, int body,
		int frame, logic [TIME_W-1:0] stamp);
		msg_t m;
		m.func = f;
		m.msg_type = BYTE_W'(kind);
		m.byte_zero = BYTE_W'(b0);
		m.byte_one = BYTE_W'(b1);
		m.byte_two = BYTE_W'(b2);
		m.body_length = BYTE_W'(body);
		m.frame_length = BYTE_W'(frame);
		m.now_ms = stamp;
		return m;
	endfunction

	// Most random beats are well formed: a type that the registers recognize
	// and a frame length that equals header plus body, so that a replay of the
	// same message really matches its slot. A share of the beats replays an
	// earlier message, a few forget the table, and the rest is pure noise.
	function automatic msg_t random_message();
		msg_t m;
		int   pick;
		int   kind;
		pick = $urandom_range(0, 99);
		m.func = FUNC_REMEMBER;
		m.msg_type = BYTE_W'($urandom_range(0, 255));
		m.byte_zero = BYTE_W'($urandom_range(0, 255));
		m.byte_one = BYTE_W'($urandom_range(0, 255));
		m.byte_two = BYTE_W'($urandom_range(0, 255));
		m.body_length = BYTE_W'($urandom_range(0, 255));
		m.frame_length = BYTE_W'($urandom_range(0, 255));
		m.now_ms = TIME_W'($urandom());
		if (pick < 2) begin
			m.func = FUNC_FORGET;
		end else if (pick < 32 && recent_messages.size() != 0) begin
			m = recent_messages[$urandom_range(0, recent_messages.size() - 1)];
			m.now_ms = TIME_W'($urandom());
		end else if (pick < 85) begin
			kind = $urandom_range(0, 19);
			if (kind < 9)
				m.msg_type = tracker.announce_code;
			else if (kind < 17)
				m.msg_type = tracker.signature_code;
			// Narrow byte values make different messages share a reference.
			if ($urandom_range(0, 9) < 3) begin
				m.byte_zero = BYTE_W'($urandom_range(0, 3));
				m.byte_one = BYTE_W'($urandom_range(0, 3));
				m.byte_two = BYTE_W'($urandom_range(0, 3));
			end
			if ($urandom_range(0, 3) == 0)
				m.body_length = BYTE_W'($urandom_range(0, 3));
			else
				m.body_length = BYTE_W'($urandom_range(0, 239));
			m.frame_length = m.body_length + BYTE_W'(HEADER_BYTES_DEF);
		end
		if (m.func == FUNC_REMEMBER) begin
			recent_messages.push_back(m);
			if (recent_messages.size() > HISTORY_DEPTH)
				void'(recent_messages.pop_front());
		end
		return m;
	endfunction

	// Offers one beat and returns at the edge that accepts it. Valid stays high
	// between back-to-back beats so that it is never lowered and raised again
	// within one time step.
	task automatic send_message(msg_t m, int gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= m.func;
		req_ch.msg_type <= m.msg_type;
		req_ch.byte_zero <= m.byte_zero;
		req_ch.byte_one <= m.byte_one;
		req_ch.byte_two <= m.byte_two;
		req_ch.body_length <= m.body_length;
		req_ch.frame_length <= m.frame_length;
		req_ch.now_ms <= m.now_ms;
		do @(posedge clk); while (!req_ch.ready);
		tracker.note_message(m);
	endtask

	// Every beat produces a result, so once the last one has come out the block
	// is idle; a settling wait follows before the registers are touched.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_registers(logic [CFG_DATA_W-1:0] announce,
		logic [CFG_DATA_W-1:0] signature);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_ANNOUNCEMENT;
		cfg_data <= announce;
		@(posedge clk);
		tracker.set_register(REG_ANNOUNCEMENT, announce);
		cfg_index <= REG_SIGNATURE;
		cfg_data <= signature;
		@(posedge clk);
		tracker.set_register(REG_SIGNATURE, signature);
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: checks every accepted result beat and throttles ready. A hold
	// request from the stimulus is counted out here, cycle by cycle, while the
	// sender keeps offering beats, so the output register and then the input
	// back up.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				tracker.check_outcome('{rsp_ch.stored, rsp_ch.duplicate, rsp_ch.slot,
					rsp_ch.evicted});
			if (hold_request) begin
				stall_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (!steady && $urandom_range(0, 99) < 25) begin
				rsp_ch.ready <= 1'b0;
				stall_left = idle_length() - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Any stretch without a single beat on either channel that is far longer
	// than the slowest correct case means the block has hung.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		int n;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_REMEMBER;
		req_ch.msg_type = '0;
		req_ch.byte_zero = '0;
		req_ch.byte_one = '0;
		req_ch.byte_two = '0;
		req_ch.body_length = '0;
		req_ch.frame_length = '0;
		req_ch.now_ms = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run with the register values that reset leaves: type 0
		// is the announcement, type 1 the signature. The first message lands in
		// slot 0 of the empty table and its replay is a duplicate.
		send_message(compose(FUNC_REMEMBER, 0, 8'hAA, 8'h34, 8'h12, 0, 16, '0), pause_before());
		send_message(compose(FUNC_REMEMBER, 0, 8'hAA, 8'h34, 8'h12, 0, 16, '1), pause_before());
		// Signature reference with all ones at the largest well-formed length.
		send_message(compose(FUNC_REMEMBER, 1, 8'hFF, 8'hFF, 8'h00, 239, 255, 1), pause_before());
		send_message(compose(FUNC_REMEMBER, 1, 8'hFF, 8'hFF, 8'h00, 239, 255, 2), pause_before());
		// Unknown type with the largest body: header plus body exceeds any frame
		// length a slot can hold, so the same message is stored twice.
		send_message(compose(FUNC_REMEMBER, 255, 8'h12, 8'h34, 8'h56, 255, 255, 3),
			pause_before());
		send_message(compose(FUNC_REMEMBER, 255, 8'h12, 8'h34, 8'h56, 255, 255, 4),
			pause_before());
		// Unknown types all carry reference zero, so a second one with equal size
		// is a duplicate although its payload differs.
		send_message(compose(FUNC_REMEMBER, 2, 0, 0, 0, 0, 16, 5), pause_before());
		send_message(compose(FUNC_REMEMBER, 3, 5, 6, 7, 0, 16, 6), pause_before());
		// Same reference as slot 0 but a different size is not a duplicate.
		send_message(compose(FUNC_REMEMBER, 0, 0, 8'h34, 8'h12, 1, 16, 7), pause_before());
		send_message(compose(FUNC_FORGET, 255, 255, 255, 255, 255, 255, '1), pause_before());
		send_message(compose(FUNC_REMEMBER, 0, 8'hAA, 8'h34, 8'h12, 0, 16, 8), pause_before());
		// A signature reference equal to a stored announcement reference matches.
		send_message(compose(FUNC_REMEMBER, 1, 8'h34, 8'h12, 0, 0, 16, 9), pause_before());
		send_message(compose(FUNC_FORGET, 0, 0, 0, 0, 0, 0, '0), pause_before());
		send_message(compose(FUNC_FORGET, 0, 0, 0, 0, 0, 0, '0), pause_before());
		// Frame length zero stored into the cleared table: cleared slots and this
		// one never match, so both copies are stored.
		send_message(compose(FUNC_REMEMBER, 0, 0, 0, 0, 0, 0, 10), pause_before());
		send_message(compose(FUNC_REMEMBER, 0, 0, 0, 0, 0, 0, 11), pause_before());

		// Random part in phases with different register settings: the extremes,
		// equal codes (announcement must win), a random pair, the reset pair swapped.
		announce_plan[3] = CFG_DATA_W'($urandom_range(0, 255));
		signature_plan[3] = CFG_DATA_W'($urandom_range(0, 255));
		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			program_registers(announce_plan[phase], signature_plan[phase]);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				steady = (n >= 60 && n < 90);
				if (phase == 1 && n == 60)
					hold_request = 1'b1;
				send_message(random_message(), pause_before());
			end
		end

		drain();
		steady = 1'b1;
		repeat (END_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
